>>> rtl/rpj_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the disparity reprojection block
// no dependencies

package rpj_pkg;

  localparam int DispW  = 16;
  localparam int CoordW = 12;
  localparam int ColorW = 24;
  localparam int RegW   = 32;
  localparam int ProdW  = 48;
  localparam int NumW   = 34;
  localparam int QuoW   = 33;
  localparam int FracSh = 28;
  localparam int DivLat = 37;
  localparam int InW    = 64;
  localparam int OutW   = 128;

  typedef enum logic [2:0] {
    REG_Q03 = 3'd0,
    REG_Q13 = 3'd1,
    REG_Q23 = 3'd2,
    REG_Q32 = 3'd3,
    REG_Q33 = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic              valid;
    logic              wzero;
    logic [ColorW-1:0] color;
  } side_t;

endpackage

>>> rtl/rpj_front.sv
`timescale 1ns / 1ps
// front stages: input register, disparity multiply, w and numerators
// uses rpj_pkg

module rpj_front #(
  parameter int COORD_BITS = 12
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                en,
  input  logic                                in_valid,
  input  logic signed [rpj_pkg::DispW-1:0]    disparity,
  input  logic [rpj_pkg::CoordW-1:0]          column,
  input  logic [rpj_pkg::CoordW-1:0]          row,
  input  logic [rpj_pkg::ColorW-1:0]          pixel_color,
  input  logic signed [rpj_pkg::RegW-1:0]     q03,
  input  logic signed [rpj_pkg::RegW-1:0]     q13,
  input  logic signed [rpj_pkg::RegW-1:0]     q23,
  input  logic signed [rpj_pkg::RegW-1:0]     q32,
  input  logic signed [rpj_pkg::RegW-1:0]     q33,
  output rpj_pkg::side_t                      side,
  output logic signed [rpj_pkg::ProdW-1:0]    w,
  output logic signed [rpj_pkg::NumW-1:0]     nx,
  output logic signed [rpj_pkg::NumW-1:0]     ny,
  output logic signed [rpj_pkg::NumW-1:0]     nz
);

  localparam logic [rpj_pkg::CoordW-1:0] CMask =
    rpj_pkg::CoordW'((64'd1 << COORD_BITS) - 64'd1);

  logic                               v0, v1;
  logic signed [rpj_pkg::DispW-1:0]   d0;
  logic [rpj_pkg::CoordW-1:0]         col0, row0;
  logic [rpj_pkg::ColorW-1:0]         c0, c1;
  logic signed [rpj_pkg::ProdW-1:0]   prod1;
  logic signed [rpj_pkg::NumW-1:0]    nx1, ny1, nz1;
  logic signed [rpj_pkg::NumW-1:0]    sx, sy;
  logic signed [rpj_pkg::ProdW-1:0]   w_next;

  always_comb begin
    sx = rpj_pkg::NumW'(q03) + $signed({6'd0, col0, 16'd0});
    sy = rpj_pkg::NumW'(q13) + $signed({6'd0, row0, 16'd0});
    w_next = prod1 + $signed({{12{q33[rpj_pkg::RegW-1]}}, q33, 4'd0});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      side.valid <= 1'b0;
    end else if (en) begin
      v0 <= in_valid && (disparity > 0);
      v1 <= v0;
      side.valid <= v1;
    end
    if (en) begin
      d0    <= disparity;
      col0  <= column & CMask;
      row0  <= row & CMask;
      c0    <= pixel_color;
      prod1 <= rpj_pkg::ProdW'(q32) * rpj_pkg::ProdW'(d0);
      nx1   <= -sx;
      ny1   <= -sy;
      nz1   <= rpj_pkg::NumW'(q23);
      c1    <= c0;
      w     <= w_next;
      side.wzero <= (w_next == '0);
      side.color <= c1;
      nx    <= nx1;
      ny    <= ny1;
      nz    <= nz1;
    end
  end

endmodule

>>> rtl/rpj_div.sv
`timescale 1ns / 1ps
// pipelined restoring divider: num * 2^28 / w, rounded and saturated to 32 bits
// one quotient bit per stage; uses rpj_pkg

module rpj_div (
  input  logic                             clk,
  input  logic                             en,
  input  logic signed [rpj_pkg::NumW-1:0]  num,
  input  logic signed [rpj_pkg::ProdW-1:0] w,
  output logic [rpj_pkg::RegW-1:0]         quo,
  output logic                             ovf
);

  localparam int QW = rpj_pkg::QuoW;
  localparam int PW = rpj_pkg::ProdW;
  localparam int DW = 61;

  logic [31:0]    un0;
  logic [PW-1:0]  uw0, uw1;
  logic           neg0, neg1;
  logic [DW-1:0]  dvd1;

  logic [PW-1:0]  r   [QW+1];
  logic [QW-1:0]  lo  [QW+1];
  logic [QW-1:0]  q   [QW+1];
  logic [PW-1:0]  uwp [QW+1];
  logic           ngp [QW+1];
  logic           bgp [QW+1];

  logic [PW-1:0]  t   [QW];
  logic           ge  [QW];

  logic [QW-1:0]  qf;
  logic [QW-1:0]  qneg;

  always_comb begin
    for (int k = 0; k < QW; k++) begin
      t[k]  = {r[k][PW-2:0], lo[k][QW-1]};
      ge[k] = t[k] >= uwp[k];
    end
    qf   = q[QW];
    qneg = -qf;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      un0  <= 32'(num[rpj_pkg::NumW-1] ? -num : num);
      uw0  <= PW'(w[PW-1] ? -w : w);
      neg0 <= num[rpj_pkg::NumW-1] != w[PW-1];
      dvd1 <= ({29'd0, un0} << rpj_pkg::FracSh) + DW'(uw0 >> 1);
      uw1  <= uw0;
      neg1 <= neg0;
      r[0]   <= PW'(dvd1[DW-1:QW]);
      lo[0]  <= dvd1[QW-1:0];
      q[0]   <= '0;
      uwp[0] <= uw1;
      ngp[0] <= neg1;
      bgp[0] <= PW'(dvd1[DW-1:QW]) >= uw1;
      for (int k = 0; k < QW; k++) begin
        r[k+1]   <= ge[k] ? t[k] - uwp[k] : t[k];
        lo[k+1]  <= {lo[k][QW-2:0], 1'b0};
        q[k+1]   <= {q[k][QW-2:0], ge[k]};
        uwp[k+1] <= uwp[k];
        ngp[k+1] <= ngp[k];
        bgp[k+1] <= bgp[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (!ngp[QW]) begin
        if (bgp[QW] || qf[QW-1] || qf[QW-2]) begin
          quo <= 32'h7FFF_FFFF;
          ovf <= 1'b1;
        end else begin
          quo <= qf[31:0];
          ovf <= 1'b0;
        end
      end else begin
        if (bgp[QW] || qf > 33'h0_8000_0000) begin
          quo <= 32'h8000_0000;
          ovf <= 1'b1;
        end else begin
          quo <= qneg[31:0];
          ovf <= 1'b0;
        end
      end
    end
  end

endmodule

>>> rtl/disparity_to_point_reproject_top.sv
`timescale 1ns / 1ps
// disparity reprojection top: config registers, front stages, three dividers
// uses rpj_pkg, rpj_front, rpj_div
// each divider has 33 quotient stages
// throughput: one pixel per cycle; the whole pipeline stalls only while an output waits
// pixels with disparity zero or less leave no output
// reset (rst, synchronous): pipeline emptied, registers to q23=1.0, q33=1.0, others 0

module disparity_to_point_reproject_top #(
  parameter int COORD_BITS = 12
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // disparity[15:0], column[27:16], row[39:28], pixel_color[63:40]
  input  logic [rpj_pkg::InW-1:0]       s_tdata,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // point_x[31:0], point_y[63:32], point_z[95:64], red[103:96], green[111:104],
  // blue[119:112], overflow[120], zero fill above
  output logic [rpj_pkg::OutW-1:0]      m_tdata,
  input  logic                          cfg_we,
  input  logic [2:0]                    cfg_index,
  input  logic [rpj_pkg::RegW-1:0]      cfg_data
);

  localparam int L = rpj_pkg::DivLat;

  logic                                en;
  logic signed [rpj_pkg::RegW-1:0]     q03, q13, q23, q32, q33;
  rpj_pkg::side_t                      fside;
  rpj_pkg::side_t                      line [L];
  logic signed [rpj_pkg::ProdW-1:0]    w;
  logic signed [rpj_pkg::NumW-1:0]     nx, ny, nz;
  logic [rpj_pkg::RegW-1:0]            px, py, pz;
  logic                                ox, oy, oz;
  logic                                wz, ovf;

  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      q03 <= '0;
      q13 <= '0;
      q23 <= 32'sd65536;
      q32 <= '0;
      q33 <= 32'sd16777216;
    end else if (cfg_we) begin
      case (cfg_index)
        rpj_pkg::REG_Q03: q03 <= cfg_data;
        rpj_pkg::REG_Q13: q13 <= cfg_data;
        rpj_pkg::REG_Q23: q23 <= cfg_data;
        rpj_pkg::REG_Q32: q32 <= cfg_data;
        rpj_pkg::REG_Q33: q33 <= cfg_data;
        default: ;
      endcase
    end
  end

  rpj_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk         (clk),
    .rst         (rst),
    .en          (en),
    .in_valid    (s_tvalid),
    .disparity   ($signed(s_tdata[15:0])),
    .column      (s_tdata[27:16]),
    .row         (s_tdata[39:28]),
    .pixel_color (s_tdata[63:40]),
    .q03         (q03),
    .q13         (q13),
    .q23         (q23),
    .q32         (q32),
    .q33         (q33),
    .side        (fside),
    .w           (w),
    .nx          (nx),
    .ny          (ny),
    .nz          (nz)
  );

  rpj_div u_div_x (.clk(clk), .en(en), .num(nx), .w(w), .quo(px), .ovf(ox));
  rpj_div u_div_y (.clk(clk), .en(en), .num(ny), .w(w), .quo(py), .ovf(oy));
  rpj_div u_div_z (.clk(clk), .en(en), .num(nz), .w(w), .quo(pz), .ovf(oz));

  // side data line matching the divider latency
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < L; i++) line[i].valid <= 1'b0;
    end else if (en) begin
      line[0].valid <= fside.valid;
      for (int i = 1; i < L; i++) line[i].valid <= line[i-1].valid;
    end
    if (en) begin
      line[0].wzero <= fside.wzero;
      line[0].color <= fside.color;
      for (int i = 1; i < L; i++) begin
        line[i].wzero <= line[i-1].wzero;
        line[i].color <= line[i-1].color;
      end
    end
  end

  assign m_tvalid = line[L-1].valid;
  assign wz       = line[L-1].wzero;
  assign ovf      = wz || ox || oy || oz;

  assign m_tdata = {7'd0, ovf,
                    line[L-1].color[7:0],
                    line[L-1].color[15:8],
                    line[L-1].color[23:16],
                    wz ? 32'd0 : pz,
                    wz ? 32'd0 : py,
                    wz ? 32'd0 : px};

endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps
// testbench for disparity_to_point_reproject_top: directed pixel table, then random pixels
// predicts each point in fixed point, checks every output transfer; uses rpj_pkg

module testbench;

  localparam int LATENCY = 40;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] pz;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic        ovf;
  } point_t;

  typedef struct {
    logic [15:0] disp;
    logic [11:0] col;
    logic [11:0] row;
    logic [23:0] color;
    bit          typed;
    point_t      pt;
  } pixel_row_t;

  logic clk;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  logic [rpj_pkg::InW-1:0] s_tdata;
  logic m_tvalid;
  logic m_tready;
  logic [rpj_pkg::OutW-1:0] m_tdata;
  logic cfg_we;
  logic [2:0] cfg_index;
  logic [rpj_pkg::RegW-1:0] cfg_data;

  logic signed [31:0] r_q03, r_q13, r_q23, r_q32, r_q33;
  point_t expected_points[$];
  int errors;
  int points_seen;
  int cycles;
  bit rx_idle_on;
  bit rx_hold;
  int ovf_seen;

  disparity_to_point_reproject_top #(.COORD_BITS(12)) DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // rounded, saturated num * 2^28 / w
  function automatic logic [31:0] scaled_quotient(input longint num, input longint w,
                                                  inout logic ovf);
    logic [63:0] un;
    logic [63:0] uw;
    logic [63:0] q;
    bit neg;
    un = (num < 0) ? -num : num;
    uw = (w < 0) ? -w : w;
    q = ((un << 28) + (uw >> 1)) / uw;
    neg = (num < 0) != (w < 0);
    if (!neg) begin
      if (q > 64'h7FFF_FFFF) begin
        ovf = 1'b1;
        return 32'h7FFF_FFFF;
      end
      return q[31:0];
    end
    if (q > 64'h8000_0000) begin
      ovf = 1'b1;
      return 32'h8000_0000;
    end
    return 32'd0 - q[31:0];
  endfunction

  function automatic bit reproject(input logic [15:0] disp, input logic [11:0] col,
                                   input logic [11:0] row, input logic [23:0] color,
                                   output point_t pt);
    longint d;
    longint w;
    longint nx, ny, nz;
    logic ovf;
    d = longint'($signed(disp));
    pt = '0;
    if (d <= 0) return 0;
    w = longint'(r_q32) * d + longint'(r_q33) * 16;
    nx = -(longint'(r_q03) + longint'(col) * 65536);
    ny = -(longint'(r_q13) + longint'(row) * 65536);
    nz = longint'(r_q23);
    ovf = 1'b0;
    if (w == 0) begin
      ovf = 1'b1;
    end else begin
      pt.px = scaled_quotient(nx, w, ovf);
      pt.py = scaled_quotient(ny, w, ovf);
      pt.pz = scaled_quotient(nz, w, ovf);
    end
    pt.red = color[23:16];
    pt.green = color[15:8];
    pt.blue = color[7:0];
    pt.ovf = ovf;
    return 1;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  task automatic idle_cycles(input int n);
    repeat (n) @(posedge clk);
  endtask

  task automatic write_reg(input rpj_pkg::reg_idx_t idx, input logic [31:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    case (idx)
      rpj_pkg::REG_Q03: r_q03 = value;
      rpj_pkg::REG_Q13: r_q13 = value;
      rpj_pkg::REG_Q23: r_q23 = value;
      rpj_pkg::REG_Q32: r_q32 = value;
      rpj_pkg::REG_Q33: r_q33 = value;
      default: ;
    endcase
  endtask

  task automatic drain();
    while (expected_points.size() != 0) @(posedge clk);
    idle_cycles(LATENCY + 4);
  endtask

  task automatic set_config(input logic [31:0] a, input logic [31:0] b, input logic [31:0] c,
                            input logic [31:0] d, input logic [31:0] e);
    drain();
    write_reg(rpj_pkg::REG_Q03, a);
    write_reg(rpj_pkg::REG_Q13, b);
    write_reg(rpj_pkg::REG_Q23, c);
    write_reg(rpj_pkg::REG_Q32, d);
    write_reg(rpj_pkg::REG_Q33, e);
    cfg_we <= 1'b0;
  endtask

  // holds s_tvalid across back-to-back pixels, with random idle gaps when allow_gap is set; one pixel per call
  task automatic send_pixel(input logic [15:0] disp, input logic [11:0] col,
                            input logic [11:0] row, input logic [23:0] color,
                            input bit typed, input point_t typed_pt, input bit allow_gap);
    point_t pt;
    if (allow_gap && $urandom_range(0, 7) == 0) begin
      s_tvalid <= 1'b0;
      idle_cycles($urandom_range(1, 12));
    end
    s_tvalid <= 1'b1;
    s_tdata <= {color, row, col, disp};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (reproject(disp, col, row, color, pt)) begin
      if (typed && pt != typed_pt)
        $display("table row disagrees with predictor for disparity %h", disp);
      expected_points = {expected_points, (typed ? typed_pt : pt)};
    end
  endtask

  // output checker
  always @(posedge clk) begin
    point_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got.px = m_tdata[31:0];
      got.py = m_tdata[63:32];
      got.pz = m_tdata[95:64];
      got.red = m_tdata[103:96];
      got.green = m_tdata[111:104];
      got.blue = m_tdata[119:112];
      got.ovf = m_tdata[120];
      if (m_tdata[rpj_pkg::OutW-1:121] != '0)
        report_mismatch("fill", 32'(m_tdata[rpj_pkg::OutW-1:121]), 32'd0);
      if (expected_points.size() == 0) begin
        $display("unexpected point transfer at cycle %0d", cycles);
        errors++;
      end else begin
        want = expected_points.pop_front();
        points_seen++;
        if (got.ovf) ovf_seen++;
        if (got.px != want.px) report_mismatch("point_x", got.px, want.px);
        if (got.py != want.py) report_mismatch("point_y", got.py, want.py);
        if (got.pz != want.pz) report_mismatch("point_z", got.pz, want.pz);
        if (got.red != want.red)
          report_mismatch("red", 32'(got.red), 32'(want.red));
        if (got.green != want.green)
          report_mismatch("green", 32'(got.green), 32'(want.green));
        if (got.blue != want.blue)
          report_mismatch("blue", 32'(got.blue), 32'(want.blue));
        if (got.ovf != want.ovf)
          report_mismatch("overflow", 32'(got.ovf), 32'(want.ovf));
      end
    end
  end

  // receiver stalls
  initial begin
    m_tready <= 1'b0;
    @(negedge rst);
    forever begin
      if (rx_hold) begin
        m_tready <= 1'b0;
        @(posedge clk);
      end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
        m_tready <= 1'b0;
        idle_cycles($urandom_range(1, 12));
      end else begin
        m_tready <= 1'b1;
        idle_cycles($urandom_range(1, 20));
      end
    end
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("timeout after %0d cycles", cycles);
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    pixel_row_t pixel_table[$];
    pixel_row_t r;
    point_t pt;
    int hold_len;
    errors = 0;
    points_seen = 0;
    ovf_seen = 0;
    rx_idle_on = 1'b1;
    rx_hold = 1'b0;
    rst <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata <= '0;
    cfg_we <= 1'b0;
    cfg_index <= rpj_pkg::REG_Q03;
    cfg_data <= '0;
    r_q03 = 0; r_q13 = 0; r_q23 = 65536; r_q32 = 0; r_q33 = 32'h0100_0000;
    idle_cycles(4);
    rst <= 1'b0;
    @(posedge clk);

    // after reset w = 1.0: x = -col, y = -row, z = 1.0
    r = '{16'h0001, 12'd0, 12'd0, 24'h010203, 1, '{0, 0, 32'h0001_0000, 8'h01, 8'h02, 8'h03, 0}};
    pixel_table = {pixel_table, r};
    r = '{16'h7FFF, 12'hFFF, 12'hFFF, 24'hFFFFFF, 1,
          '{32'hF001_0000, 32'hF001_0000, 32'h0001_0000, 8'hFF, 8'hFF, 8'hFF, 0}};
    pixel_table = {pixel_table, r};
    r = '{16'h0000, 12'd5, 12'd5, 24'h123456, 1, '0};
    pixel_table = {pixel_table, r};
    r = '{16'h8000, 12'd5, 12'd5, 24'h123456, 1, '0};
    pixel_table = {pixel_table, r};
    r = '{16'hFFFF, 12'd1, 12'd1, 24'hABCDEF, 1, '0};
    pixel_table = {pixel_table, r};
    r = '{16'h0010, 12'd1, 12'd2, 24'hA5C35A, 0, '0};
    pixel_table = {pixel_table, r};
    foreach (pixel_table[i])
      send_pixel(pixel_table[i].disp, pixel_table[i].col, pixel_table[i].row,
                 pixel_table[i].color, pixel_table[i].typed, pixel_table[i].pt, 0);
    s_tvalid <= 1'b0;

    // w zero: q33 = 0, q32 = 0
    set_config(0, 0, 32'h0001_0000, 0, 0);
    r = '{16'h0020, 12'd3, 12'd4, 24'h00FF00, 1, '{0, 0, 0, 8'h00, 8'hFF, 8'h00, 1}};
    send_pixel(r.disp, r.col, r.row, r.color, 1, r.pt, 0);
    s_tvalid <= 1'b0;
    // tiny positive w saturates z high and x, y low
    set_config(32'h0000_0001, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0001, 0);
    send_pixel(16'h0001, 12'd0, 12'd0, 24'h0, 0, '0, 0);
    send_pixel(16'h0001, 12'd100, 12'd7, 24'hFFFFFF, 0, '0, 0);
    s_tvalid <= 1'b0;
    // negative w for the first pixel, extreme registers
    set_config(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
    send_pixel(16'h7FFF, 12'hFFF, 12'h000, 24'h112233, 0, '0, 0);
    send_pixel(16'h0001, 12'h000, 12'hFFF, 24'h445566, 0, '0, 0);
    s_tvalid <= 1'b0;
    set_config(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    send_pixel(16'h4000, 12'h800, 12'h800, 24'h778899, 0, '0, 0);
    send_pixel(16'h0001, 12'h001, 12'h7FF, 24'h000001, 0, '0, 0);
    s_tvalid <= 1'b0;

    // random phases with realistic and extreme calibrations
    for (int phase = 0; phase < 7; phase++) begin
      case (phase)
        0, 3, 6: set_config(-($urandom_range(200, 2000) << 16), -($urandom_range(200, 2000) << 16),
                            $urandom_range(300, 3000) << 16, $urandom_range(1, 1 << 22),
                            $urandom_range(0, 1) ? 0 : $urandom());
        1, 4: set_config($urandom(), $urandom(), $urandom(), $urandom(), $urandom());
        default: set_config($urandom(), $urandom(), $urandom_range(0, 1 << 20),
                            $urandom_range(0, 1 << 12), $urandom_range(0, 1 << 8));
      endcase
      if (phase == 6) rx_idle_on = 1'b0;
      if (phase == 2) begin
        // long receiver hold while input keeps coming
        rx_hold = 1'b1;
        fork
          begin
            hold_len = 0;
            while (hold_len < 300) begin
              @(posedge clk);
              hold_len++;
            end
            rx_hold = 1'b0;
          end
        join_none
      end
      for (int k = 0; k < 150; k++) begin
        logic [15:0] disp;
        disp = ($urandom_range(0, 9) == 0) ? 16'($urandom()) :
               ($urandom_range(0, 3) == 0) ? 16'($urandom_range(1, 16)) :
               16'($urandom_range(1, 16'h7FFF));
        send_pixel(disp, 12'($urandom()), 12'($urandom()), 24'($urandom()), 0, '0,
                   phase != 6);
      end
      s_tvalid <= 1'b0;
      if (phase == 4) drain();
    end

    drain();
    $display("checked %0d points, %0d flagged overflow", points_seen, ovf_seen);
    $display("covered reset defaults, w zero, saturation, eleven register sets, stalls");
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
